@@ rtl/sed_pkg.sv @@
`default_nettype none

package sed_pkg;

  // Decoder modes.
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_OCT    = 3'd2,
    MODE_HEX    = 3'd3,
    MODE_U4     = 3'd4,
    MODE_U8     = 3'd5
  } mode_t;

  // Error codes carried on every result.
  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_OCT   = 3'd1;
  localparam logic [2:0] ERR_HEX   = 3'd2;
  localparam logic [2:0] ERR_UNI   = 3'd3;
  localparam logic [2:0] ERR_TRUNC = 3'd4;

  // Most results one input byte can produce.
  localparam int unsigned MAX_RES = 4;
  localparam int unsigned NUM_W   = $clog2(MAX_RES + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_RES);

  // Octal and UTF-8 limits.
  localparam logic [31:0] OCT_MAX   = 32'o377;
  localparam logic [31:0] UTF8_LIM1 = 32'h80;
  localparam logic [31:0] UTF8_LIM2 = 32'd2048;
  localparam logic [31:0] UTF8_LIM3 = 32'd65536;
  localparam logic [31:0] UTF8_LIM4 = 32'd1114112;

  // All results of one input byte, moved through the queue as one entry.
  typedef struct packed {
    logic [NUM_W-1:0]           num;
    logic [MAX_RES-1:0][7:0]    data;
    logic [MAX_RES-1:0]         vld;
    logic [MAX_RES-1:0][2:0]    err;
    logic                       last;
  } pkt_t;

  // Queue status seen by the front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Appends one result to a packet; an invalid result carries a zero byte.
  function automatic pkt_t pkt_put(pkt_t p, logic [7:0] b, logic v, logic [2:0] e);
    pkt_t q;
    q = p;
    q.data[p.num[IDX_W-1:0]] = v ? b : 8'h00;
    q.vld[p.num[IDX_W-1:0]]  = v;
    q.err[p.num[IDX_W-1:0]]  = e;
    q.num = p.num + NUM_W'(1);
    return q;
  endfunction

endpackage

`default_nettype wire

@@ rtl/string_escape_decoder_core.sv @@
// A byte's results are registered in the queue and then in the back's held packet.
// Throughput: one byte per cycle while each byte gives at most one result and out_ready
// is high; a byte with N results sends one per beat; a two-entry queue lets input run ahead.
// Reset: synchronous, active-low rst_n; decoder returns to plain text, queue and output empty.
`default_nettype none

module string_escape_decoder_core
  import sed_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic [2:0]      out_error_code,
  output logic            out_last
);

  // The front decodes each byte into a packet holding all of its results. Bytes that
  // start or continue an escape and yield nothing push no packet. The back then sends
  // the packet out one result per beat.
  q_stat_t q_stat;
  logic    q_push, q_pop;
  pkt_t    q_wdata, q_rdata;

  sed_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // Short queue so a multi-byte UTF-8 drain does not stall the scanner at once.
  sed_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_stat  (q_stat)
  );

  sed_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

`ifndef SYNTHESIS
  // The front must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full) else $error("queue push while full");

  // The back must never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty) else $error("queue pop while empty");

  // A pushed packet holds between one and four results.
  a_pkt_size: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_wdata.num != '0 && q_wdata.num <= NUM_W'(MAX_RES)))
    else $error("bad packet size");

  // A valid decoded byte always carries error code ERR_NONE.
  a_byte_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_byte_valid) |-> (out_error_code == ERR_NONE))
    else $error("valid byte with error code");
`endif

endmodule

`default_nettype wire

@@ rtl/sed_front.sv @@
`default_nettype none

module sed_front
  import sed_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  input  wire q_stat_t    q_stat,
  output logic            q_push,
  output pkt_t            q_wdata
);

  localparam logic [7:0] CH_BSLASH = 8'h5C;

  mode_t       mode_r, mode_nxt, f_mode, esc_mode;
  logic [31:0] acc_r, acc_nxt, f_acc, acc_oct, acc_hex;
  logic [3:0]  cnt_r, cnt_nxt, f_cnt, cnt_inc;
  logic [2:0]  err_r, err_nxt, f_err, t_err;
  logic [7:0]  esc_val;
  logic        is_bs, is_oct, is_hex, oct_done, hex_done, accept;
  logic [3:0]  hex_v;
  pkt_t        pkt;

  function automatic logic [4:0] hex_dec(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 4'(c - "0")};
    end else if (c >= "A" && c <= "F") begin
      r = {1'b1, 4'(c - "A" + 8'd10)};
    end else if (c >= "a" && c <= "f") begin
      r = {1'b1, 4'(c - "a" + 8'd10)};
    end
    return r;
  endfunction

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // Classify the incoming byte.
  always_comb begin
    is_bs    = (in_byte == CH_BSLASH);
    is_oct   = (in_byte >= "0") && (in_byte <= "7");
    {is_hex, hex_v} = hex_dec(in_byte);
    acc_oct  = {acc_r[28:0], in_byte[2:0]};
    acc_hex  = {acc_r[27:0], hex_v};
    cnt_inc  = cnt_r + 4'd1;
    oct_done = (cnt_inc == 4'd3);
    hex_done = ((mode_r == MODE_HEX) && (cnt_inc == 4'd2)) ||
               ((mode_r == MODE_U4) && (cnt_inc == 4'd4)) ||
               ((mode_r == MODE_U8) && (cnt_inc == 4'd8));
    esc_mode = MODE_NORMAL;
    esc_val  = in_byte;
    case (in_byte)
      "a":     esc_val = 8'd7;
      "b":     esc_val = 8'd8;
      "f":     esc_val = 8'd12;
      "n":     esc_val = 8'd10;
      "r":     esc_val = 8'd13;
      "t":     esc_val = 8'd9;
      "v":     esc_val = 8'd11;
      "o":     esc_mode = MODE_OCT;
      "x":     esc_mode = MODE_HEX;
      "u":     esc_mode = MODE_U4;
      "U":     esc_mode = MODE_U8;
      default: esc_val = in_byte;
    endcase
  end

  // Next state.
  always_comb begin
    f_mode = mode_r;
    f_acc  = acc_r;
    f_cnt  = cnt_r;
    f_err  = err_r;
    if (err_r == ERR_NONE) begin
      case (mode_r)
        MODE_NORMAL: begin
          if (is_bs) f_mode = MODE_ESC;
        end
        MODE_ESC: begin
          f_acc  = 32'd0;
          f_cnt  = 4'd0;
          f_mode = esc_mode;
        end
        MODE_OCT: begin
          if (is_oct) begin
            f_acc = acc_oct;
            f_cnt = cnt_inc;
            if (oct_done) begin
              f_mode = MODE_NORMAL;
              if (acc_oct > OCT_MAX) f_err = ERR_OCT;
            end
          end else if (cnt_r == 4'd0) begin
            f_err  = ERR_OCT;
            f_mode = MODE_NORMAL;
          end else begin
            f_mode = is_bs ? MODE_ESC : MODE_NORMAL;
          end
        end
        MODE_HEX, MODE_U4, MODE_U8: begin
          if (!is_hex) begin
            f_err  = ERR_HEX;
            f_mode = MODE_NORMAL;
          end else begin
            f_acc = acc_hex;
            f_cnt = cnt_inc;
            if (hex_done) begin
              f_mode = MODE_NORMAL;
              if (mode_r != MODE_HEX && acc_hex >= UTF8_LIM4) f_err = ERR_UNI;
            end
          end
        end
        default: begin
          f_mode = is_bs ? MODE_ESC : MODE_NORMAL;
        end
      endcase
    end

    // Error that an unfinished escape leaves on the final byte.
    t_err = f_err;
    if (f_err == ERR_NONE) begin
      case (f_mode)
        MODE_NORMAL:                t_err = ERR_NONE;
        MODE_ESC:                   t_err = ERR_TRUNC;
        MODE_OCT:                   t_err = (f_cnt == 4'd0) ? ERR_OCT : ERR_NONE;
        MODE_HEX, MODE_U4, MODE_U8: t_err = ERR_HEX;
        default:                    t_err = ERR_NONE;
      endcase
    end

    if (in_last) begin
      mode_nxt = MODE_NORMAL;
      acc_nxt  = 32'd0;
      cnt_nxt  = 4'd0;
      err_nxt  = ERR_NONE;
    end else begin
      mode_nxt = f_mode;
      acc_nxt  = f_acc;
      cnt_nxt  = f_cnt;
      err_nxt  = f_err;
    end
  end

  // Results of this byte.
  always_comb begin
    pkt = '0;
    if (err_r == ERR_NONE) begin
      case (mode_r)
        MODE_NORMAL: begin
          if (!is_bs) pkt = pkt_put(pkt, in_byte, 1'b1, ERR_NONE);
        end
        MODE_ESC: begin
          if (esc_mode == MODE_NORMAL) pkt = pkt_put(pkt, esc_val, 1'b1, ERR_NONE);
        end
        MODE_OCT: begin
          if (is_oct) begin
            if (oct_done) begin
              if (acc_oct > OCT_MAX) pkt = pkt_put(pkt, 8'h00, 1'b0, ERR_OCT);
              else pkt = pkt_put(pkt, acc_oct[7:0], 1'b1, ERR_NONE);
            end
          end else if (cnt_r == 4'd0) begin
            pkt = pkt_put(pkt, 8'h00, 1'b0, ERR_OCT);
          end else begin
            pkt = pkt_put(pkt, acc_r[7:0], 1'b1, ERR_NONE);
            if (!is_bs) pkt = pkt_put(pkt, in_byte, 1'b1, ERR_NONE);
          end
        end
        MODE_HEX, MODE_U4, MODE_U8: begin
          if (!is_hex) begin
            pkt = pkt_put(pkt, 8'h00, 1'b0, ERR_HEX);
          end else if (hex_done) begin
            if (mode_r == MODE_HEX) begin
              pkt = pkt_put(pkt, acc_hex[7:0], 1'b1, ERR_NONE);
            end else if (acc_hex < UTF8_LIM1) begin
              pkt = pkt_put(pkt, acc_hex[7:0], 1'b1, ERR_NONE);
            end else if (acc_hex < UTF8_LIM2) begin
              pkt = pkt_put(pkt, {3'b110, acc_hex[10:6]}, 1'b1, ERR_NONE);
              pkt = pkt_put(pkt, {2'b10, acc_hex[5:0]}, 1'b1, ERR_NONE);
            end else if (acc_hex < UTF8_LIM3) begin
              pkt = pkt_put(pkt, {4'b1110, acc_hex[15:12]}, 1'b1, ERR_NONE);
              pkt = pkt_put(pkt, {2'b10, acc_hex[11:6]}, 1'b1, ERR_NONE);
              pkt = pkt_put(pkt, {2'b10, acc_hex[5:0]}, 1'b1, ERR_NONE);
            end else if (acc_hex < UTF8_LIM4) begin
              pkt = pkt_put(pkt, {5'b11110, acc_hex[20:18]}, 1'b1, ERR_NONE);
              pkt = pkt_put(pkt, {2'b10, acc_hex[17:12]}, 1'b1, ERR_NONE);
              pkt = pkt_put(pkt, {2'b10, acc_hex[11:6]}, 1'b1, ERR_NONE);
              pkt = pkt_put(pkt, {2'b10, acc_hex[5:0]}, 1'b1, ERR_NONE);
            end else begin
              pkt = pkt_put(pkt, 8'h00, 1'b0, ERR_UNI);
            end
          end
        end
        default: begin
          if (!is_bs) pkt = pkt_put(pkt, in_byte, 1'b1, ERR_NONE);
        end
      endcase
    end

    if (in_last) begin
      if (f_err == ERR_NONE && f_mode == MODE_OCT && f_cnt != 4'd0) begin
        pkt = pkt_put(pkt, f_acc[7:0], 1'b1, ERR_NONE);
      end else if (f_err == ERR_NONE && t_err != ERR_NONE) begin
        pkt = pkt_put(pkt, 8'h00, 1'b0, t_err);
      end
      if (pkt.num == '0) pkt = pkt_put(pkt, 8'h00, 1'b0, t_err);
      pkt.last = 1'b1;
    end
  end

  assign q_push  = accept && (pkt.num != '0);
  assign q_wdata = pkt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      acc_r  <= 32'd0;
      cnt_r  <= 4'd0;
      err_r  <= ERR_NONE;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sed_queue.sv @@
`default_nettype none

module sed_queue
  import sed_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_push,
  input  wire pkt_t q_wdata,
  input  wire logic q_pop,
  output pkt_t      q_rdata,
  output q_stat_t   q_stat
);

  // Two-entry queue of packets.
  pkt_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign q_rdata      = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);

  always_comb begin
    count_nxt = count_r;
    if (q_push && !q_pop) count_nxt = count_r + 2'd1;
    else if (!q_push && q_pop) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (q_push) mem_r[wr_ptr_r] <= q_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (q_push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sed_back.sv @@
`default_nettype none

module sed_back
  import sed_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire q_stat_t    q_stat,
  input  wire pkt_t       q_rdata,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic [2:0]      out_error_code,
  output logic            out_last
);

  pkt_t             cur_r;
  logic [IDX_W-1:0] idx_r;
  logic             busy_r;
  logic             at_end, fin, load;

  // Results leave one per beat from the held packet.
  assign at_end = ({1'b0, idx_r} + NUM_W'(1)) == cur_r.num;
  assign fin    = busy_r && out_ready && at_end;
  assign load   = !q_stat.empty && (!busy_r || fin);
  assign q_pop  = load;

  assign out_valid      = busy_r;
  assign out_byte       = cur_r.data[idx_r];
  assign out_byte_valid = cur_r.vld[idx_r];
  assign out_error_code = cur_r.err[idx_r];
  assign out_last       = cur_r.last && at_end;

  always_ff @(posedge clk) begin
    if (load) cur_r <= q_rdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (fin) begin
      busy_r <= 1'b0;
    end else if (busy_r && out_ready) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

endmodule

`default_nettype wire
